/* hdl/ppti_pkg.sv */
// Package for the planar pose twist integrator: fixed-point constants
// and the CORDIC arctangent table. No dependencies.
`default_nettype none
package ppti_pkg;
    localparam int CordicSteps = 16;
    localparam int CntW = $clog2(CordicSteps + 1);
    localparam logic signed [16:0] PiQ = 17'sd25736;
    localparam logic signed [16:0] TwoPiQ = 17'sd51472;
    localparam logic signed [33:0] Pi30 = 34'sd3373259426;
    localparam logic signed [33:0] HalfPi30 = 34'sd1686629713;
    localparam logic signed [33:0] CordicK30 = 34'sd652032874;

    function automatic logic signed [33:0] atan30(input logic [4:0] i);
        logic signed [33:0] r;
        unique case (i)
            5'd0: r = 34'sd843314856;
            5'd1: r = 34'sd497837829;
            5'd2: r = 34'sd263043836;
            5'd3: r = 34'sd133525158;
            5'd4: r = 34'sd67021686;
            5'd5: r = 34'sd33543515;
            5'd6: r = 34'sd16775850;
            5'd7: r = 34'sd8388437;
            5'd8: r = 34'sd4194282;
            5'd9: r = 34'sd2097149;
            5'd10: r = 34'sd1048575;
            5'd11: r = 34'sd524287;
            5'd12: r = 34'sd262143;
            5'd13: r = 34'sd131071;
            5'd14: r = 34'sd65535;
            5'd15: r = 34'sd32767;
            5'd16: r = 34'sd16383;
            5'd17: r = 34'sd8191;
            5'd18: r = 34'sd4095;
            5'd19: r = 34'sd2047;
            5'd20: r = 34'sd1023;
            5'd21: r = 34'sd511;
            5'd22: r = 34'sd255;
            5'd23: r = 34'sd127;
            default: r = 34'sd0;
        endcase
        return r;
    endfunction
endpackage
`default_nettype wire

/* hdl/planar_pose_twist_integrator.sv */
// Top level of the planar pose twist integrator: stream ports, sequencer and pose state.
// Depends on ppti_pkg, ppti_divider, ppti_cordic and ppti_dot.
`default_nettype none
// Integrates one body twist per item onto the stored planar pose and returns
// the new pose. One item is in work at a time. A turning item makes two
// 46-step serial divisions for the turn centre, two 16-step CORDIC passes and
// four 9-digit serial dot products, all on single shared units, then wraps the
// heading and loads the result. An item with zero turn skips the divisions,
// the first CORDIC pass and its two dot products. The result waits in an
// output register while the next item is taken, and a new result that finds
// that register still full stalls the block. Reset clears the pose to zero.
module planar_pose_twist_integrator (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [79:0] s_tdata,  // turn_step[15:0], fwd_step[31:0], side_step[31:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [87:0]      m_tdata   // pose_x[31:0], pose_y, pose_heading[15:0], saturated
);
    import ppti_pkg::*;

    typedef enum logic [11:0] {
        ST_IDLE = 12'b000000000001,
        ST_DIVX = 12'b000000000010,
        ST_DIVY = 12'b000000000100,
        ST_CORW = 12'b000000001000,
        ST_DW1  = 12'b000000010000,
        ST_DW2  = 12'b000000100000,
        ST_CORH = 12'b000001000000,
        ST_DH1  = 12'b000010000000,
        ST_DH2  = 12'b000100000000,
        ST_HOLD = 12'b001000000000,
        ST_WAIT = 12'b010000000000,
        ST_FIN  = 12'b100000000000
    } state_t;

    state_t state_reg, state_next;
    logic signed [15:0] w_reg, w_next;
    logic signed [31:0] vx_reg, vx_next, vy_reg, vy_next;
    logic signed [31:0] px_reg, px_next, py_reg, py_next;
    logic signed [15:0] hd_reg, hd_next;
    logic signed [31:0] cx_reg, cx_next, cy_reg, cy_next;
    logic signed [35:0] dx_reg, dx_next, dy_reg, dy_next;
    logic signed [33:0] co_reg, co_next, si_reg, si_next;
    logic               sat_reg, sat_next, wz_reg, wz_next;
    logic               ov_reg, ov_next;
    logic [87:0]        out_reg, out_next;
    logic               ov_vld_reg, ov_vld_next;

    logic               div_start, div_done, cor_start, cor_done, dot_start, dot_done;
    logic signed [45:0] div_dvd;
    logic signed [46:0] div_q;
    logic signed [33:0] cor_ang, cor_cos, cor_sin;
    logic signed [33:0] dot_a, dot_b;
    logic signed [35:0] dot_u, dot_v;
    logic signed [37:0] dot_r;
    logic signed [31:0] sat_q;
    logic               q_ovf;
    logic signed [38:0] pos_sum;
    logic signed [31:0] pos_sat;
    logic               pos_ovf;
    logic signed [16:0] hsum, hwrap;

    ppti_divider u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start), .dividend(div_dvd),
        .divisor(w_reg), .done(div_done), .quotient(div_q)
    );
    ppti_cordic u_cor (
        .aclk(aclk), .aresetn(aresetn), .start(cor_start), .angle(cor_ang),
        .done(cor_done), .cos_out(cor_cos), .sin_out(cor_sin)
    );
    ppti_dot u_dot (
        .aclk(aclk), .aresetn(aresetn), .start(dot_start), .coef_a(dot_a),
        .vec_u(dot_u), .coef_b(dot_b), .vec_v(dot_v), .done(dot_done), .result(dot_r)
    );

    // Saturation of the centre offset and of the new position.
    always_comb begin
        q_ovf = (div_q > 47'sd2147483647) || (div_q < -47'sd2147483648);
        sat_q = (div_q > 47'sd2147483647) ? 32'sh7fffffff :
                (div_q < -47'sd2147483648) ? 32'sh80000000 : div_q[31:0];
        pos_sum = (state_reg == ST_DH1) ? 39'(px_reg) + 39'(dot_r) : 39'(py_reg) + 39'(dot_r);
        pos_ovf = (pos_sum > 39'sd2147483647) || (pos_sum < -39'sd2147483648);
        pos_sat = (pos_sum > 39'sd2147483647) ? 32'sh7fffffff :
                  (pos_sum < -39'sd2147483648) ? 32'sh80000000 : pos_sum[31:0];
        // Heading sum lies within one turn of the range.
        hsum = 17'(hd_reg) + 17'(w_reg);
        if (hsum > PiQ) hwrap = hsum - TwoPiQ;
        else if (hsum <= -PiQ) hwrap = hsum + TwoPiQ;
        else hwrap = hsum;
    end

    // Sequencer over the shared divider, CORDIC and dot-product units.
    always_comb begin
        state_next = state_reg;
        w_next = w_reg; vx_next = vx_reg; vy_next = vy_reg;
        px_next = px_reg; py_next = py_reg; hd_next = hd_reg;
        cx_next = cx_reg; cy_next = cy_reg; dx_next = dx_reg; dy_next = dy_reg;
        co_next = co_reg; si_next = si_reg; sat_next = sat_reg; wz_next = wz_reg;
        ov_next = ov_reg;
        out_next = out_reg;
        ov_vld_next = ov_vld_reg;
        div_start = 1'b0; cor_start = 1'b0; dot_start = 1'b0;
        div_dvd = (state_reg == ST_DIVX) ? 46'(vy_reg) <<< 13 : -(46'(vx_reg) <<< 13);
        cor_ang = (state_reg == ST_CORH || state_reg == ST_DW2 || state_reg == ST_IDLE) ?
                  34'(hd_reg) <<< 17 : 34'(w_reg) <<< 17;
        dot_u = dx_reg; dot_v = dy_reg;
        if (state_reg == ST_DW1 || state_reg == ST_DH1) begin
            dot_a = co_reg; dot_b = -si_reg;
        end else begin
            dot_a = si_reg; dot_b = co_reg;
        end
        if (state_reg == ST_DW1 || state_reg == ST_DW2) begin
            dot_u = 36'(cx_reg); dot_v = 36'(cy_reg);
        end
        if (m_tready) ov_vld_next = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    w_next = s_tdata[15:0];
                    vx_next = s_tdata[47:16];
                    vy_next = s_tdata[79:48];
                    sat_next = 1'b0;
                    wz_next = (s_tdata[15:0] == 16'd0);
                    dx_next = 36'($signed(s_tdata[47:16]));
                    dy_next = 36'($signed(s_tdata[79:48]));
                    if (s_tdata[15:0] == 16'd0) begin
                        cor_start = 1'b1;
                        state_next = ST_CORH;
                    end else begin
                        state_next = ST_DIVX;
                    end
                end
            end
            ST_DIVX: begin
                if (!ov_reg) begin
                    div_start = 1'b1;
                    ov_next = 1'b1;
                end else if (div_done) begin
                    cx_next = sat_q;
                    sat_next = sat_reg | q_ovf;
                    ov_next = 1'b0;
                    state_next = ST_DIVY;
                end
            end
            ST_DIVY: begin
                if (!ov_reg) begin
                    div_start = 1'b1;
                    ov_next = 1'b1;
                end else if (div_done) begin
                    cy_next = sat_q;
                    sat_next = sat_reg | q_ovf;
                    ov_next = 1'b0;
                    cor_start = 1'b1;
                    state_next = ST_CORW;
                end
            end
            ST_CORW: begin
                if (cor_done) begin
                    co_next = cor_cos; si_next = cor_sin;
                    state_next = ST_DW1;
                end
            end
            ST_DW1: begin
                if (!ov_reg) begin
                    dot_start = 1'b1; ov_next = 1'b1;
                end else if (dot_done) begin
                    dx_next = 36'(dot_r - 38'(cx_reg));
                    ov_next = 1'b0;
                    state_next = ST_DW2;
                end
            end
            ST_DW2: begin
                if (!ov_reg) begin
                    dot_start = 1'b1; ov_next = 1'b1;
                end else if (dot_done) begin
                    dy_next = 36'(dot_r - 38'(cy_reg));
                    ov_next = 1'b0;
                    cor_start = 1'b1;
                    state_next = ST_CORH;
                end
            end
            ST_CORH: begin
                if (cor_done) begin
                    co_next = cor_cos; si_next = cor_sin;
                    state_next = ST_DH1;
                end
            end
            ST_DH1: begin
                if (!ov_reg) begin
                    dot_start = 1'b1; ov_next = 1'b1;
                end else if (dot_done) begin
                    px_next = pos_sat;
                    sat_next = sat_reg | pos_ovf;
                    ov_next = 1'b0;
                    state_next = ST_DH2;
                end
            end
            ST_DH2: begin
                if (!ov_reg) begin
                    dot_start = 1'b1; ov_next = 1'b1;
                end else if (dot_done) begin
                    py_next = pos_sat;
                    sat_next = sat_reg | pos_ovf;
                    ov_next = 1'b0;
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                hd_next = hwrap[15:0];
                state_next = ST_HOLD;
            end
            ST_HOLD: begin
                if (!ov_vld_reg || m_tready) begin
                    out_next = {7'd0, sat_reg, hd_reg, py_reg, px_reg};
                    ov_vld_next = 1'b1;
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            px_reg <= '0; py_reg <= '0; hd_reg <= '0;
            ov_reg <= 1'b0; ov_vld_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            px_reg <= px_next; py_reg <= py_next; hd_reg <= hd_next;
            ov_reg <= ov_next; ov_vld_reg <= ov_vld_next;
        end
        w_reg <= w_next; vx_reg <= vx_next; vy_reg <= vy_next;
        cx_reg <= cx_next; cy_reg <= cy_next; dx_reg <= dx_next; dy_reg <= dy_next;
        co_reg <= co_next; si_reg <= si_next; sat_reg <= sat_next; wz_reg <= wz_next;
        out_reg <= out_next;
    end

    assign s_tready = (state_reg == ST_IDLE) && !wz_reg | (state_reg == ST_IDLE);
    assign m_tvalid = ov_vld_reg;
    assign m_tdata = out_reg;
endmodule
`default_nettype wire

/* hdl/ppti_divider.sv */
// Radix-2 restoring divider: one quotient bit per cycle, truncates toward zero.
// Depends on ppti_pkg.
`default_nettype none
module ppti_divider (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                start,
    input  wire logic signed [45:0]  dividend,
    input  wire logic signed [15:0]  divisor,
    output logic                     done,
    output logic signed [46:0]       quotient
);
    import ppti_pkg::*;

    logic [45:0] q_reg, q_next;
    logic [16:0] r_reg, r_next;
    logic [15:0] d_reg, d_next;
    logic        neg_reg, neg_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [17:0] trial;
    logic [45:0] mag_n;

    // Magnitudes are taken once, then one bit is shifted in per cycle.
    always_comb begin
        q_next = q_reg;
        r_next = r_reg;
        d_next = d_reg;
        neg_next = neg_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        mag_n = dividend[45] ? 46'(-dividend) : 46'(dividend);
        trial = {r_reg, q_reg[45]} - {2'b00, d_reg};
        if (start) begin
            q_next = mag_n;
            r_next = '0;
            d_next = divisor[15] ? 16'(-divisor) : 16'(divisor);
            neg_next = dividend[45] ^ divisor[15];
            cnt_next = 6'd46;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!trial[17]) begin
                r_next = trial[16:0];
                q_next = {q_reg[44:0], 1'b1};
            end else begin
                r_next = {r_reg[15:0], q_reg[45]};
                q_next = {q_reg[44:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
        neg_reg <= neg_next;
    end

    assign done = done_reg;
    assign quotient = neg_reg ? -$signed({1'b0, q_reg}) : $signed({1'b0, q_reg});
endmodule
`default_nettype wire

/* hdl/ppti_cordic.sv */
// Rotation-mode CORDIC, one micro-rotation per cycle, giving cos and sin in Q4.30.
// Depends on ppti_pkg.
`default_nettype none
module ppti_cordic (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               start,
    input  wire logic signed [33:0] angle,
    output logic                    done,
    output logic signed [33:0]      cos_out,
    output logic signed [33:0]      sin_out
);
    import ppti_pkg::*;

    logic signed [33:0] x_reg, x_next, y_reg, y_next, z_reg, z_next;
    logic               neg_reg, neg_next;
    logic [CntW-1:0]    i_reg, i_next;
    logic               busy_reg, busy_next, done_reg, done_next;
    logic signed [33:0] xs, ys;

    // Half-turn fold on start, then one shift-add step per cycle.
    always_comb begin
        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        neg_next = neg_reg;
        i_next = i_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        xs = x_reg >>> i_reg;
        ys = y_reg >>> i_reg;
        if (start) begin
            x_next = CordicK30;
            y_next = '0;
            i_next = '0;
            busy_next = 1'b1;
            if (angle > HalfPi30) begin
                z_next = angle - Pi30;
                neg_next = 1'b1;
            end else if (angle < -HalfPi30) begin
                z_next = angle + Pi30;
                neg_next = 1'b1;
            end else begin
                z_next = angle;
                neg_next = 1'b0;
            end
        end else if (busy_reg) begin
            if (!z_reg[33]) begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                z_next = z_reg - atan30(5'(i_reg));
            end else begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                z_next = z_reg + atan30(5'(i_reg));
            end
            i_next = i_reg + 1'b1;
            if (i_reg == CntW'(CordicSteps - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            i_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            i_reg <= i_next;
        end
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
        neg_reg <= neg_next;
    end

    assign done = done_reg;
    assign cos_out = neg_reg ? -x_reg : x_reg;
    assign sin_out = neg_reg ? -y_reg : y_reg;
endmodule
`default_nettype wire

/* hdl/ppti_dot.sv */
// Serial dot product round((a*u + b*v) / 2^30), four-bit digits of u and v per cycle.
// Depends on ppti_pkg.
`default_nettype none
module ppti_dot (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               start,
    input  wire logic signed [33:0] coef_a,
    input  wire logic signed [35:0] vec_u,
    input  wire logic signed [33:0] coef_b,
    input  wire logic signed [35:0] vec_v,
    output logic                    done,
    output logic signed [37:0]      result
);
    import ppti_pkg::*;

    // Accumulate a*u + b*v LSB-digit first; the low bits retire into a shift reg.
    logic signed [33:0] a_reg, a_next, b_reg, b_next;
    logic [35:0]        u_reg, u_next, v_reg, v_next;
    logic signed [39:0] acc_reg, acc_next;
    logic [35:0]        low_reg, low_next;
    logic [3:0]         cnt_reg, cnt_next;
    logic               busy_reg, busy_next, done_reg, done_next;
    logic signed [4:0]  du, dv;
    logic signed [39:0] sum;
    logic signed [75:0] full;

    always_comb begin
        a_next = a_reg;
        b_next = b_reg;
        u_next = u_reg;
        v_next = v_reg;
        acc_next = acc_reg;
        low_next = low_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        // Top digit is signed, lower digits unsigned.
        du = (cnt_reg == 4'd8) ? $signed({u_reg[3], u_reg[3:0]}) : $signed({1'b0, u_reg[3:0]});
        dv = (cnt_reg == 4'd8) ? $signed({v_reg[3], v_reg[3:0]}) : $signed({1'b0, v_reg[3:0]});
        sum = acc_reg + 40'(a_reg * du) + 40'(b_reg * dv);
        if (start) begin
            a_next = coef_a;
            b_next = coef_b;
            u_next = vec_u;
            v_next = vec_v;
            acc_next = '0;
            cnt_next = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            u_next = {4'b0, u_reg[35:4]};
            v_next = {4'b0, v_reg[35:4]};
            low_next = {sum[3:0], low_reg[35:4]};
            acc_next = sum >>> 4;
            cnt_next = cnt_reg + 4'd1;
            if (cnt_reg == 4'd8) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
        a_reg <= a_next;
        b_reg <= b_next;
        u_reg <= u_next;
        v_reg <= v_next;
        acc_reg <= acc_next;
        low_reg <= low_next;
    end

    // Add half an LSB of the result, then drop 30 fraction bits.
    assign full = {acc_reg, low_reg} + 76'sd536870912;
    assign result = full[67:30];
    assign done = done_reg;
endmodule
`default_nettype wire
